// ===== rtl/csa_pkg.sv =====
// Shared constants for the chunked slot allocator: operations, status codes, sizes.
package csa_pkg;

    localparam int unsigned MAX_SLOTS       = 1024;
    localparam int unsigned FREE_DEPTH_DEF  = 1024;

    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned EPC_W    = 9;
    localparam int unsigned BYTES_W  = 13;
    localparam int unsigned OFFSET_W = 20;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [1:0] ST_STACK_FULL = 2'd2;
    localparam logic [1:0] ST_RANGE      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENTS_PER_CHUNK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES      = 8'd1;

    localparam logic [EPC_W-1:0]   EPC_RESET   = 9'd64;
    localparam logic [EPC_W-1:0]   EPC_MAX     = 9'd256;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd16;
    localparam logic [BYTES_W-1:0] BYTES_MAX   = 13'd4096;

endpackage

// ===== rtl/csa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csa_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/chunked_slot_allocator_top.sv =====
// Top level of the chunked slot allocator: free stack, bump counter and chunk mapping.
//
//   channel  signals                                  direction
//   request  in_valid/in_ready, operation, slot_index in
//   result   out_valid/out_ready, granted_slot ...    out
//   config   cfg_valid/cfg_ready, cfg_index, cfg_data in
//
// Free, clear and exhausted alloc go from idle straight to the finish state, which registers the result.
// Bump alloc and get pass through the divide and multiply states first; reused alloc adds one free-stack read.
// The divide step is shared and yields one quotient bit per cycle over 10 bits,
// followed by one multiply step for the byte offset.
// Reset clears the counters and stack depth; stack contents stay undefined.
// A held result stalls the sequencer in its last state; the config port never stalls.
module chunked_slot_allocator_top
    #(
    parameter int unsigned FREE_DEPTH = csa_pkg::FREE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      operation,
    input  logic [csa_pkg::SLOT_W-1:0]      slot_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [csa_pkg::SLOT_W-1:0]      granted_slot,
    output logic [csa_pkg::SLOT_W-1:0]      chunk_number,
    output logic [csa_pkg::OFFSET_W-1:0]    byte_offset,
    output logic                            chunk_added,
    output logic                            from_free_list,
    output logic [csa_pkg::COUNT_W-1:0]     used_count,
    output logic [1:0]                      status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [csa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import csa_pkg::*;

    localparam int unsigned AW = $clog2(FREE_DEPTH);
    localparam int unsigned DW = $clog2(FREE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_MUL,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [DW-1:0]        free_depth_reg, free_depth_next;
    logic [COUNT_W-1:0]   bump_reg, bump_next;
    logic [COUNT_W-1:0]   chunks_reg, chunks_next;
    logic [EPC_W-1:0]     epc_cfg_reg, epc_cfg_next;
    logic [BYTES_W-1:0]   bytes_cfg_reg, bytes_cfg_next;

    logic                 is_get_reg, is_get_next;
    logic                 is_bump_reg, is_bump_next;
    logic [SLOT_W-1:0]    q_reg, q_next;
    logic [EPC_W-1:0]     r_reg, r_next;
    logic [3:0]           cnt_reg, cnt_next;

    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [OFFSET_W-1:0]  res_offset_reg, res_offset_next;
    logic                 res_added_reg, res_added_next;
    logic                 res_reused_reg, res_reused_next;
    logic [1:0]           res_status_reg, res_status_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    granted_slot_reg, granted_slot_next;
    logic [SLOT_W-1:0]    chunk_number_reg, chunk_number_next;
    logic [OFFSET_W-1:0]  byte_offset_reg, byte_offset_next;
    logic                 chunk_added_reg, chunk_added_next;
    logic                 from_free_list_reg, from_free_list_next;
    logic [COUNT_W-1:0]   used_count_reg, used_count_next;
    logic [1:0]           status_reg, status_next;

    logic [EPC_W-1:0]     epc_eff;
    logic [BYTES_W-1:0]   bytes_eff;
    logic                 accept;
    logic                 idx_oor;
    logic [EPC_W-1:0]     trial;
    logic                 trial_ge;
    logic [SLOT_W+BYTES_W-1:0] prod;
    logic                 chunk_new;
    logic [DW-1:0]        depth_dec;

    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [SLOT_W-1:0]    ram_rdata;

    csa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (FREE_DEPTH)
    ) u_free_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (slot_index),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    assign epc_eff   = (epc_cfg_reg == '0) ? EPC_W'(1) :
                       (epc_cfg_reg > EPC_MAX) ? EPC_MAX : epc_cfg_reg;
    assign bytes_eff = (bytes_cfg_reg == '0) ? BYTES_W'(1) :
                       (bytes_cfg_reg > BYTES_MAX) ? BYTES_MAX : bytes_cfg_reg;

    assign idx_oor   = (COUNT_W'(slot_index) >= COUNT_W'(MAX_SLOTS));
    assign depth_dec = free_depth_reg - DW'(1);

    assign trial     = {r_reg[EPC_W-2:0], q_reg[SLOT_W-1]};
    assign trial_ge  = (trial >= epc_eff);
    assign prod      = (SLOT_W+BYTES_W)'(r_reg[EPC_W-2:0]) * (SLOT_W+BYTES_W)'(bytes_eff);
    assign chunk_new = (COUNT_W'(q_reg) >= chunks_reg);

    assign ram_waddr = free_depth_reg[AW-1:0];
    assign ram_raddr = depth_dec[AW-1:0];
    assign ram_we    = accept && (operation == OP_FREE) && !idx_oor
                       && (free_depth_reg < DW'(FREE_DEPTH));
    assign ram_re    = accept && (operation == OP_ALLOC) && (free_depth_reg != '0);

    always_comb
    begin
        state_next          = state_reg;
        free_depth_next     = free_depth_reg;
        bump_next           = bump_reg;
        chunks_next         = chunks_reg;
        epc_cfg_next        = epc_cfg_reg;
        bytes_cfg_next      = bytes_cfg_reg;
        is_get_next         = is_get_reg;
        is_bump_next        = is_bump_reg;
        q_next              = q_reg;
        r_next              = r_reg;
        cnt_next            = cnt_reg;
        res_slot_next       = res_slot_reg;
        res_offset_next     = res_offset_reg;
        res_added_next      = res_added_reg;
        res_reused_next     = res_reused_reg;
        res_status_next     = res_status_reg;
        out_valid_next      = out_valid_reg;
        granted_slot_next   = granted_slot_reg;
        chunk_number_next   = chunk_number_reg;
        byte_offset_next    = byte_offset_reg;
        chunk_added_next    = chunk_added_reg;
        from_free_list_next = from_free_list_reg;
        used_count_next     = used_count_reg;
        status_next         = status_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ELEMENTS_PER_CHUNK: epc_cfg_next   = cfg_data[EPC_W-1:0];
                CFG_ELEMENT_BYTES:      bytes_cfg_next = cfg_data[BYTES_W-1:0];
                default:                ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_slot_next   = '0;
                    q_next          = '0;
                    r_next          = '0;
                    cnt_next        = 4'(SLOT_W - 1);
                    res_offset_next = '0;
                    res_added_next  = 1'b0;
                    res_reused_next = 1'b0;
                    res_status_next = ST_OK;
                    is_get_next     = 1'b0;
                    is_bump_next    = 1'b0;
                    state_next      = S_FINISH;
                    unique case (operation)
                        OP_ALLOC:
                        begin
                            if (free_depth_reg != '0)
                            begin
                                free_depth_next = depth_dec;
                                res_reused_next = 1'b1;
                                state_next      = S_READ;
                            end
                            else if (bump_reg >= COUNT_W'(MAX_SLOTS))
                            begin
                                res_status_next = ST_EXHAUSTED;
                            end
                            else
                            begin
                                res_slot_next = bump_reg[SLOT_W-1:0];
                                q_next        = bump_reg[SLOT_W-1:0];
                                bump_next     = bump_reg + COUNT_W'(1);
                                is_bump_next  = 1'b1;
                                state_next    = S_DIV;
                            end
                        end
                        OP_FREE:
                        begin
                            if (idx_oor)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (free_depth_reg >= DW'(FREE_DEPTH))
                            begin
                                res_status_next = ST_STACK_FULL;
                            end
                            else
                            begin
                                free_depth_next = free_depth_reg + DW'(1);
                            end
                        end
                        OP_GET:
                        begin
                            res_slot_next   = slot_index;
                            q_next          = slot_index;
                            is_get_next     = 1'b1;
                            res_status_next = idx_oor ? ST_RANGE : ST_OK;
                            state_next      = S_DIV;
                        end
                        OP_CLEAR:
                        begin
                            bump_next       = '0;
                            free_depth_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                res_slot_next = ram_rdata;
                q_next        = ram_rdata;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                r_next = trial_ge ? (trial - epc_eff) : trial;
                q_next = {q_reg[SLOT_W-2:0], trial_ge};
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_MUL:
            begin
                res_offset_next = prod[OFFSET_W-1:0];
                if (is_bump_reg && chunk_new)
                begin
                    chunks_next    = COUNT_W'(q_reg) + COUNT_W'(1);
                    res_added_next = 1'b1;
                end
                if (is_get_reg && chunk_new)
                begin
                    res_status_next = ST_RANGE;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    granted_slot_next   = res_slot_reg;
                    chunk_number_next   = q_reg;
                    byte_offset_next    = res_offset_reg;
                    chunk_added_next    = res_added_reg;
                    from_free_list_next = res_reused_reg;
                    used_count_next     = bump_reg;
                    status_next         = res_status_reg;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            free_depth_reg     <= '0;
            bump_reg           <= '0;
            chunks_reg         <= '0;
            epc_cfg_reg        <= EPC_RESET;
            bytes_cfg_reg      <= BYTES_RESET;
            is_get_reg         <= 1'b0;
            is_bump_reg        <= 1'b0;
            q_reg              <= '0;
            r_reg              <= '0;
            cnt_reg            <= '0;
            res_slot_reg       <= '0;
            res_offset_reg     <= '0;
            res_added_reg      <= 1'b0;
            res_reused_reg     <= 1'b0;
            res_status_reg     <= ST_OK;
            out_valid_reg      <= 1'b0;
            granted_slot_reg   <= '0;
            chunk_number_reg   <= '0;
            byte_offset_reg    <= '0;
            chunk_added_reg    <= 1'b0;
            from_free_list_reg <= 1'b0;
            used_count_reg     <= '0;
            status_reg         <= ST_OK;
        end
        else
        begin
            state_reg          <= state_next;
            free_depth_reg     <= free_depth_next;
            bump_reg           <= bump_next;
            chunks_reg         <= chunks_next;
            epc_cfg_reg        <= epc_cfg_next;
            bytes_cfg_reg      <= bytes_cfg_next;
            is_get_reg         <= is_get_next;
            is_bump_reg        <= is_bump_next;
            q_reg              <= q_next;
            r_reg              <= r_next;
            cnt_reg            <= cnt_next;
            res_slot_reg       <= res_slot_next;
            res_offset_reg     <= res_offset_next;
            res_added_reg      <= res_added_next;
            res_reused_reg     <= res_reused_next;
            res_status_reg     <= res_status_next;
            out_valid_reg      <= out_valid_next;
            granted_slot_reg   <= granted_slot_next;
            chunk_number_reg   <= chunk_number_next;
            byte_offset_reg    <= byte_offset_next;
            chunk_added_reg    <= chunk_added_next;
            from_free_list_reg <= from_free_list_next;
            used_count_reg     <= used_count_next;
            status_reg         <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted_slot   = granted_slot_reg;
    assign chunk_number   = chunk_number_reg;
    assign byte_offset    = byte_offset_reg;
    assign chunk_added    = chunk_added_reg;
    assign from_free_list = from_free_list_reg;
    assign used_count     = used_count_reg;
    assign status         = status_reg;

`ifndef SYNTHESIS
    a_one_request_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready
    ) else $error("request taken while sequencer busy");

    a_depth_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        free_depth_reg <= DW'(FREE_DEPTH)
    ) else $error("free stack depth beyond capacity");

    a_added_only_on_bump: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && chunk_added_reg |-> !from_free_list_reg && (status_reg == ST_OK)
    ) else $error("chunk added on a reused or failed alloc");

    a_exhausted_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_EXHAUSTED)
            |-> (granted_slot_reg == '0) && (byte_offset_reg == '0) && !chunk_added_reg
    ) else $error("exhausted result carries a mapping");
`endif

endmodule
